// ----- sv/assert_macros.svh -----
// Assertion macros shared by the distance-sum RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define PMDS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define PMDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/pmds_pkg.sv -----
// Shared types and constants of the pairwise Manhattan distance sum core.
// No dependencies.
package pmds_pkg;

   localparam int unsigned COORD_W = 32;
   localparam int unsigned DIM_W   = 2;
   localparam int unsigned TOTAL_W = 63;
   localparam int unsigned CFG_W   = 3;

   localparam logic [CFG_W-1:0]   DIMS_RESET = 3'd4;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH0,
      ST_FLUSH1,
      ST_COMMIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic sample;
      logic clear;
   } acc_cmd_type;

endpackage

// ----- sv/pmds_channel_if.sv -----
// Valid/ready channel interfaces for coordinate requests and distance responses.
// Depends on pmds_pkg for field widths.
interface pmds_req_if;
   logic                             valid;
   logic                             ready;
   logic [pmds_pkg::COORD_W-1:0]     coord_value;
   logic [pmds_pkg::DIM_W-1:0]       dim_index;
   logic                             last_item;

   modport source (output valid, coord_value, dim_index, last_item, input ready);
   modport sink   (input valid, coord_value, dim_index, last_item, output ready);
endinterface

interface pmds_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pmds_pkg::TOTAL_W-1:0]     total_distance;
   logic                             dropped_flag;

   modport source (output valid, total_distance, dropped_flag, input ready);
   modport sink   (input valid, total_distance, dropped_flag, output ready);
endinterface

// ----- sv/pmds_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pmds_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/pmds_accum.sv -----
// Absolute-difference and saturating running-total datapath.
// Depends on pmds_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pmds_accum #(
   parameter int unsigned STORE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pmds_pkg::acc_cmd_type         cmd,
   input  logic [STORE_WIDTH-1:0]        value,
   input  logic [STORE_WIDTH-1:0]        rd_data,
   output logic [pmds_pkg::TOTAL_W-1:0]  total
);

   localparam int unsigned TW = pmds_pkg::TOTAL_W;

   logic [STORE_WIDTH-1:0] diff_ff, diff_in;
   logic                   diff_vld_ff, diff_vld_in;
   logic [TW-1:0]          total_ff, total_in;
   logic [TW:0]            sum;

   always_comb begin
      diff_in     = (value >= rd_data) ? (value - rd_data) : (rd_data - value);
      diff_vld_in = cmd.sample;
      sum         = {1'b0, total_ff} + {{(TW + 1 - STORE_WIDTH){1'b0}}, diff_ff};
      total_in    = total_ff;
      if (cmd.clear) begin
         total_in = '0;
      end else if (diff_vld_ff) begin
         total_in = sum[TW] ? pmds_pkg::TOTAL_MAX : sum[TW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_vld_ff <= 1'b0;
         total_ff    <= '0;
      end else begin
         diff_vld_ff <= diff_vld_in;
         total_ff    <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
   end

   assign total = total_ff;

   `PMDS_ASSERT(a_clear_pipe_empty, clock, reset, cmd.clear |-> !(diff_vld_ff || cmd.sample), "total cleared with a difference in flight")
   `PMDS_ASSERT_NEXT(a_total_monotonic, clock, reset, diff_vld_ff && !cmd.clear, total_ff >= $past(total_ff), "running total decreased")
   `PMDS_ASSERT(a_total_known, clock, reset, !$isunknown(total_ff), "running total unknown")

endmodule

// ----- sv/pmds_ctrl.sv -----
// Sequencer: column walk over the coordinate RAM, per-dimension counts,
// drop tracking, config register and response register. Depends on pmds_pkg,
// pmds_channel_if and assert_macros.svh.
`include "assert_macros.svh"

module pmds_ctrl #(
   parameter int unsigned MAX_POINTS  = 256,
   parameter int unsigned MAX_DIMS    = 4,
   parameter int unsigned STORE_WIDTH = 32,
   parameter int unsigned KW          = $clog2(MAX_POINTS),
   parameter int unsigned DW          = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [pmds_pkg::CFG_W-1:0]    csr_wr_data,
   pmds_req_if.sink                      req,
   pmds_rsp_if.source                    rsp,
   input  logic [pmds_pkg::TOTAL_W-1:0]  total,
   output pmds_pkg::acc_cmd_type         acc_cmd,
   output logic [STORE_WIDTH-1:0]        value,
   output logic                          ram_rd_en,
   output logic [DW+KW-1:0]              ram_rd_addr,
   output logic                          ram_wr_en,
   output logic [DW+KW-1:0]              ram_wr_addr,
   output logic [STORE_WIDTH-1:0]        ram_wr_data
);

   localparam int unsigned CW = $clog2(MAX_POINTS + 1);

   pmds_pkg::state_type state_ff, state_in;

   logic [STORE_WIDTH-1:0]       val_ff, val_in;
   logic [DW-1:0]                dim_ff, dim_in;
   logic                         last_ff, last_in;
   logic                         keep_ff, keep_in;
   logic [CW-1:0]                n_ff, n_in;
   logic [KW-1:0]                k_ff, k_in;
   logic                         rd_pend_ff, rd_pend_in;
   logic [CW-1:0]                count_ff [MAX_DIMS];
   logic [CW-1:0]                count_in [MAX_DIMS];
   logic                         drop_ff, drop_in;
   logic [pmds_pkg::CFG_W-1:0]   dims_ff, dims_in;
   logic                         rsp_vld_ff, rsp_vld_in;
   logic [pmds_pkg::TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic                         rsp_drop_ff, rsp_drop_in;

   logic          [DW-1:0] dim_sel;
   logic          [CW-1:0] cnt_sel;
   logic                   in_range;
   logic                   drop_now;
   logic                   finish_fire;

   assign dim_sel     = DW'(req.dim_index);
   assign in_range    = ({1'b0, req.dim_index} < dims_ff) && (int'(req.dim_index) < MAX_DIMS);
   assign cnt_sel     = in_range ? count_ff[dim_sel] : '0;
   assign drop_now    = !in_range || (cnt_sel == CW'(MAX_POINTS));
   assign finish_fire = (state_ff == pmds_pkg::ST_FINISH) && (!rsp_vld_ff || rsp.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pmds_pkg::ST_IDLE: begin
            if (req.valid) begin
               state_in = (drop_now || cnt_sel == '0) ? pmds_pkg::ST_COMMIT : pmds_pkg::ST_SCAN;
            end
         end
         pmds_pkg::ST_SCAN: begin
            if (CW'(k_ff) == n_ff - CW'(1)) begin
               state_in = pmds_pkg::ST_FLUSH0;
            end
         end
         pmds_pkg::ST_FLUSH0: state_in = pmds_pkg::ST_FLUSH1;
         pmds_pkg::ST_FLUSH1: state_in = pmds_pkg::ST_COMMIT;
         pmds_pkg::ST_COMMIT: state_in = last_ff ? pmds_pkg::ST_FINISH : pmds_pkg::ST_IDLE;
         pmds_pkg::ST_FINISH: begin
            if (finish_fire) begin
               state_in = pmds_pkg::ST_IDLE;
            end
         end
         default: state_in = pmds_pkg::ST_IDLE;
      endcase
   end

   // outputs and register updates
   always_comb begin
      val_in        = val_ff;
      dim_in        = dim_ff;
      last_in       = last_ff;
      keep_in       = keep_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      count_in      = count_ff;
      drop_in       = drop_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_drop_in   = rsp_drop_ff;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;
      acc_cmd.clear = 1'b0;
      dims_in       = csr_wr_en ? csr_wr_data : dims_ff;
      case (state_ff)
         pmds_pkg::ST_IDLE: begin
            if (req.valid) begin
               val_in  = req.coord_value[STORE_WIDTH-1:0];
               dim_in  = dim_sel;
               last_in = req.last_item;
               keep_in = !drop_now;
               n_in    = cnt_sel;
               k_in    = '0;
               if (drop_now) begin
                  drop_in = 1'b1;
               end
            end
         end
         pmds_pkg::ST_SCAN: begin
            ram_rd_en = 1'b1;
            k_in      = k_ff + KW'(1);
         end
         pmds_pkg::ST_COMMIT: begin
            ram_wr_en = keep_ff;
            if (keep_ff) begin
               count_in[dim_ff] = count_ff[dim_ff] + CW'(1);
            end
         end
         pmds_pkg::ST_FINISH: begin
            if (finish_fire) begin
               rsp_total_in  = total;
               rsp_drop_in   = drop_ff;
               drop_in       = 1'b0;
               acc_cmd.clear = 1'b1;
               for (int i = 0; i < MAX_DIMS; i++) begin
                  count_in[i] = '0;
               end
            end
         end
         default: begin
         end
      endcase
      rd_pend_in     = ram_rd_en;
      acc_cmd.sample = rd_pend_ff;
      rsp_vld_in     = finish_fire ? 1'b1 : (rsp_vld_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= pmds_pkg::ST_IDLE;
         rd_pend_ff <= 1'b0;
         drop_ff    <= 1'b0;
         dims_ff    <= pmds_pkg::DIMS_RESET;
         rsp_vld_ff <= 1'b0;
         for (int i = 0; i < MAX_DIMS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= rd_pend_in;
         drop_ff    <= drop_in;
         dims_ff    <= dims_in;
         rsp_vld_ff <= rsp_vld_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff       <= val_in;
      dim_ff       <= dim_in;
      last_ff      <= last_in;
      keep_ff      <= keep_in;
      n_ff         <= n_in;
      k_ff         <= k_in;
      rsp_total_ff <= rsp_total_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   assign req.ready          = (state_ff == pmds_pkg::ST_IDLE);
   assign rsp.valid          = rsp_vld_ff;
   assign rsp.total_distance = rsp_total_ff;
   assign rsp.dropped_flag   = rsp_drop_ff;
   assign value              = val_ff;
   assign ram_rd_addr        = {dim_ff, k_ff};
   assign ram_wr_addr        = {dim_ff, n_ff[KW-1:0]};
   assign ram_wr_data        = val_ff;

   `PMDS_ASSERT(a_scan_in_bounds, clock, reset, (state_ff == pmds_pkg::ST_SCAN) |-> (CW'(k_ff) < n_ff), "column walk beyond stored values")
   `PMDS_ASSERT(a_commit_has_room, clock, reset, (state_ff == pmds_pkg::ST_COMMIT && keep_ff) |-> (n_ff < CW'(MAX_POINTS)), "store into a full column")
   `PMDS_ASSERT_NEXT(a_finish_clears, clock, reset, finish_fire, rsp_vld_ff && !drop_ff, "response not loaded or drop flag not cleared")

endmodule

// ----- sv/pairwise_manhattan_distance_sum_core.sv -----
// Top level of the pairwise Manhattan distance sum core.
// Depends on pmds_pkg, pmds_channel_if, pmds_ram, pmds_accum and pmds_ctrl.
//
// Usage:
//   req_chan carries one coordinate per transaction (coord_value, dim_index,
//   last_item). Each coordinate that is not dropped is compared against every value
//   already stored for its dimension and the absolute differences are added
//   to a saturating 63-bit running total; the coordinate is then stored.
//   A transaction with last_item set produces one rsp_chan transaction with
//   total_distance and dropped_flag, after which all columns are emptied.
//   csr_wr_en/csr_wr_data set dims_in_use; write it only while idle.
// Sequence:
//   While an item is processed req_chan.ready is low: the SCAN state issues
//   one RAM read per stored value, FLUSH0 and FLUSH1 drain the pipeline and
//   COMMIT stores a kept value. Dropped items and first values go straight
//   to COMMIT. A last item then passes through FINISH, which loads the
//   response register once the previous response has been taken.
// Reset clears counts, total and drop flag and sets dims_in_use to 4; the RAM
// needs no clearing pass. A stalled response is held in its output register;
// new coordinates are still taken, and only a further last item waits.
module pairwise_manhattan_distance_sum_core #(
   parameter int unsigned MAX_POINTS  = 256,
   parameter int unsigned MAX_DIMS    = 4,
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [pmds_pkg::CFG_W-1:0]  csr_wr_data,
   pmds_req_if.sink                    req_chan,
   pmds_rsp_if.source                  rsp_chan
);

   localparam int unsigned SW = (VALUE_WIDTH < pmds_pkg::COORD_W) ? VALUE_WIDTH
                                                                  : pmds_pkg::COORD_W;
   localparam int unsigned KW = $clog2(MAX_POINTS);
   localparam int unsigned DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int unsigned AW = DW + KW;

   pmds_pkg::acc_cmd_type        acc_cmd;
   logic [SW-1:0]                value;
   logic [SW-1:0]                rd_data;
   logic [pmds_pkg::TOTAL_W-1:0] total;
   logic                         ram_rd_en;
   logic [AW-1:0]                ram_rd_addr;
   logic                         ram_wr_en;
   logic [AW-1:0]                ram_wr_addr;
   logic [SW-1:0]                ram_wr_data;

   pmds_ctrl #(
      .MAX_POINTS  (MAX_POINTS),
      .MAX_DIMS    (MAX_DIMS),
      .STORE_WIDTH (SW),
      .KW          (KW),
      .DW          (DW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .total       (total),
      .acc_cmd     (acc_cmd),
      .value       (value),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   pmds_ram #(
      .WIDTH (SW),
      .DEPTH (2 ** AW)
   ) u_coord_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_data)
   );

   pmds_accum #(
      .STORE_WIDTH (SW)
   ) u_accum (
      .clock   (clock),
      .reset   (reset),
      .cmd     (acc_cmd),
      .value   (value),
      .rd_data (rd_data),
      .total   (total)
   );

endmodule

// ----- test/pairwise_manhattan_distance_sum_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for pairwise_manhattan_distance_sum_core: a directed table, then random
// point sets under varied back-pressure. Depends on pmds_pkg, pmds_channel_if and the core.
module pairwise_manhattan_distance_sum_core_tb;

   localparam int MAX_POINTS     = 256;
   localparam int MAX_DIMS       = 4;
   localparam int LATENCY_PAUSE  = MAX_POINTS + 10;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 1500;
   localparam int PHASE_ITEMS    = 110;
   localparam int N_ROWS         = 28;

   typedef logic [pmds_pkg::COORD_W-1:0] coord_type;
   typedef logic [pmds_pkg::DIM_W-1:0]   dim_type;
   typedef logic [pmds_pkg::CFG_W-1:0]   cfg_type;
   typedef logic [pmds_pkg::TOTAL_W-1:0] total_type;

   typedef struct packed {
      total_type total_distance;
      logic      dropped_flag;
   } distance_result_type;

   typedef enum {ROW_COORD, ROW_DIMS} row_kind_type;

   typedef struct {
      row_kind_type kind;
      coord_type    value;
      dim_type      dim;
      logic         last;
      logic         typed;
      total_type    total;
      logic         dropped;
   } directed_row_type;

   // ROW_DIMS rows carry the register value in the value column
   directed_row_type directed_rows [N_ROWS] = '{
      '{ROW_COORD, 32'h0000_0005, 2'd0, 1'b1, 1'b1, 63'd0,          1'b0},
      '{ROW_COORD, 32'h0000_0000, 2'd0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_COORD, 32'hFFFF_FFFF, 2'd0, 1'b1, 1'b1, 63'hFFFF_FFFF,  1'b0},
      '{ROW_COORD, 32'd10,        2'd1, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_COORD, 32'd20,        2'd1, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_COORD, 32'd30,        2'd1, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_COORD, 32'd7,         2'd2, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_COORD, 32'd100,       2'd3, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_COORD, 32'd1,         2'd3, 1'b1, 1'b0, 63'd0,          1'b0},
      '{ROW_DIMS,  32'd2,         2'd0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_COORD, 32'd1,         2'd3, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_COORD, 32'd3,         2'd0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_COORD, 32'd4,         2'd1, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_COORD, 32'd8,         2'd0, 1'b1, 1'b0, 63'd0,          1'b0},
      '{ROW_COORD, 32'd9,         2'd2, 1'b1, 1'b1, 63'd0,          1'b1},
      '{ROW_DIMS,  32'd0,         2'd0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_COORD, 32'd7,         2'd0, 1'b1, 1'b1, 63'd0,          1'b1},
      '{ROW_DIMS,  32'd7,         2'd0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_COORD, 32'hFFFF_FFFF, 2'd3, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_COORD, 32'h0000_0000, 2'd3, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_COORD, 32'h8000_0000, 2'd3, 1'b1, 1'b0, 63'd0,          1'b0},
      '{ROW_DIMS,  32'd4,         2'd0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_COORD, 32'd9,         2'd3, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_COORD, 32'd2,         2'd3, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_DIMS,  32'd1,         2'd0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_COORD, 32'd5,         2'd3, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_COORD, 32'd1,         2'd0, 1'b1, 1'b0, 63'd0,          1'b0},
      '{ROW_DIMS,  32'd4,         2'd0, 1'b0, 1'b0, 63'd0,          1'b0}
   };

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   cfg_type            csr_wr_data;

   pmds_req_if req_chan ();
   pmds_rsp_if rsp_chan ();

   // distance predictor state
   coord_type          column_vals [MAX_DIMS][MAX_POINTS];
   int unsigned        column_fill [MAX_DIMS];
   total_type          model_total;
   logic               model_drop;
   cfg_type            model_dims;

   distance_result_type pending_totals [$];
   int unsigned         fail_count = 0;
   int unsigned         items_sent = 0;
   int unsigned         stall_cycles;
   int                  send_gap_pct = 0;
   int                  rsp_stall_pct = 0;
   bit                  hold_requested = 1'b0;
   int                  hold_left = 0;

   pairwise_manhattan_distance_sum_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   always #10 clock = ~clock;

   function automatic void clear_point_set();
      foreach (column_fill[d]) column_fill[d] = 0;
      model_total = '0;
      model_drop  = 1'b0;
   endfunction

   function automatic bit fold_coord(input coord_type v, input dim_type d,
                                     input logic l, output distance_result_type res);
      coord_type                s;
      logic [pmds_pkg::TOTAL_W:0] sum;
      int unsigned              n;
      res = '0;
      if (d >= model_dims || d >= MAX_DIMS) begin
         model_drop = 1'b1;
      end else if (column_fill[d] >= MAX_POINTS) begin
         model_drop = 1'b1;
      end else begin
         n = column_fill[d];
         for (int k = 0; k < n; k++) begin
            s   = column_vals[d][k];
            sum = {1'b0, model_total} + ((v >= s) ? v - s : s - v);
            model_total = (sum > {1'b0, pmds_pkg::TOTAL_MAX}) ? pmds_pkg::TOTAL_MAX
                                                               : sum[pmds_pkg::TOTAL_W-1:0];
         end
         column_vals[d][n] = v;
         column_fill[d]    = n + 1;
      end
      if (!l) return 1'b0;
      res.total_distance = model_total;
      res.dropped_flag   = model_drop;
      clear_point_set();
      return 1'b1;
   endfunction

   function automatic coord_type pick_coord(input int unsigned style);
      case (style)
         0: return $urandom();
         1: return $urandom_range(15);
         2: return $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(7) : $urandom_range(7);
         default: return $urandom() >> $urandom_range(31);
      endcase
   endfunction

   function automatic dim_type pick_dim();
      int unsigned span;
      span = (model_dims > MAX_DIMS) ? MAX_DIMS : model_dims;
      if (span == 0 || $urandom_range(9) == 0) return dim_type'($urandom_range(3));
      return dim_type'($urandom_range(span - 1));
   endfunction

   function automatic cfg_type pick_dims();
      int unsigned v;
      if ($urandom_range(3) != 0) return cfg_type'($urandom_range(1, 4));
      v = $urandom_range(4, 7);
      return cfg_type'((v == 4) ? 0 : v);
   endfunction

   task automatic offer_coord(input coord_type v, input dim_type d,
                              input logic l, input bit typed = 1'b0,
                              input distance_result_type typed_res = '0);
      distance_result_type res;
      @(negedge clock);
      while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid       = 1'b1;
      req_chan.coord_value = v;
      req_chan.dim_index   = d;
      req_chan.last_item   = l;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (fold_coord(v, d, l, res)) pending_totals = {pending_totals, (typed ? typed_res : res)};
      items_sent++;
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_totals.size() != 0) @(posedge clock);
   endtask

   task automatic write_dims(input cfg_type v);
      wait_all_results();
      repeat (LATENCY_PAUSE) @(posedge clock);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      model_dims  = v;
   endtask

   task automatic run_point_set(input int unsigned n_items);
      int unsigned style;
      style = $urandom_range(3);
      for (int i = 0; i < n_items; i++) offer_coord(pick_coord(style), pick_dim(), i == n_items - 1);
   endtask

   task automatic run_phase(input int gap, input int stall, input int unsigned budget);
      int unsigned first;
      send_gap_pct  = gap;
      rsp_stall_pct = stall;
      first         = items_sent;
      while (items_sent - first < budget) begin
         if ($urandom_range(6) == 0) write_dims(pick_dims());
         run_point_set(($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 10));
      end
      wait_all_results();
   endtask

   // receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready = 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_chan.ready = 1'b0;
      end else if (hold_requested) begin
         hold_requested = 1'b0;
         hold_left      = HOLD_CYCLES;
         rsp_chan.ready = 1'b0;
      end else begin
         rsp_chan.ready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : check_totals
      distance_result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_totals.size() == 0) begin
            $error("total_distance: no transaction expected, got %0d", rsp_chan.total_distance);
            fail_count++;
         end else begin
            want = pending_totals.pop_front();
            if (rsp_chan.total_distance !== want.total_distance) begin
               $error("total_distance: expected %0d, got %0d",
                      want.total_distance, rsp_chan.total_distance);
               fail_count++;
            end
            if (rsp_chan.dropped_flag !== want.dropped_flag) begin
               $error("dropped_flag: expected %0b, got %0b",
                      want.dropped_flag, rsp_chan.dropped_flag);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_chan.valid       = 1'b0;
      req_chan.coord_value = '0;
      req_chan.dim_index   = '0;
      req_chan.last_item   = 1'b0;
      model_dims           = pmds_pkg::DIMS_RESET;
      clear_point_set();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_DIMS) begin
            write_dims(directed_rows[i].value[pmds_pkg::CFG_W-1:0]);
         end else begin
            offer_coord(directed_rows[i].value, directed_rows[i].dim, directed_rows[i].last,
                        directed_rows[i].typed,
                        {directed_rows[i].total, directed_rows[i].dropped});
         end
      end

      // overfill column 0, then a couple of values in column 1
      write_dims(3'd4);
      for (int i = 0; i < MAX_POINTS + 4; i++) begin
         offer_coord($urandom(), (i < MAX_POINTS + 2) ? 2'd0 : 2'd1, i == MAX_POINTS + 3);
      end

      // long receiver hold-off while further sets are offered
      hold_requested = 1'b1;
      repeat (3) run_point_set(4);
      wait_all_results();

      run_phase(0, 0, PHASE_ITEMS);
      run_phase(69, 0, PHASE_ITEMS);
      run_phase(0, 69, PHASE_ITEMS);
      run_phase(37, 37, PHASE_ITEMS);

      wait_all_results();
      repeat (LATENCY_PAUSE) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+sv
sv/pmds_pkg.sv
sv/pmds_channel_if.sv
sv/pmds_ram.sv
sv/pmds_accum.sv
sv/pmds_ctrl.sv
sv/pairwise_manhattan_distance_sum_core.sv
test/pairwise_manhattan_distance_sum_core_tb.sv
